// ----- hdl/dcm_pkg.sv -----
// Package for the diverging colour map: widths, palette ROM and colour type.
package dcm_pkg;

   localparam int SAMPLE_W      = 26;
   localparam int FRAC_BITS_DEF = 23;
   localparam int CHAN_W        = 8;
   localparam int SEG_IDX_W     = 4;
   localparam int PAL_LAST      = 8;
   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 24;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   localparam rgb_type BLACK = '{blue: 8'h00, green: 8'h00, red: 8'h00};

   function automatic rgb_type palette(input logic [SEG_IDX_W-1:0] idx);
      rgb_type c;
      case (idx)
         4'd0:    c = '{red: 8'h00, green: 8'h00, blue: 8'h90};
         4'd1:    c = '{red: 8'h00, green: 8'h0f, blue: 8'hff};
         4'd2:    c = '{red: 8'h00, green: 8'h90, blue: 8'hff};
         4'd3:    c = '{red: 8'h0f, green: 8'hff, blue: 8'hee};
         4'd4:    c = '{red: 8'hff, green: 8'hff, blue: 8'hff};
         4'd5:    c = '{red: 8'hff, green: 8'hee, blue: 8'h00};
         4'd6:    c = '{red: 8'hff, green: 8'h70, blue: 8'h00};
         4'd7:    c = '{red: 8'hee, green: 8'h00, blue: 8'h00};
         default: c = '{red: 8'h7f, green: 8'h00, blue: 8'h00};
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/diverging_colormap_lookup_core.sv -----
// Diverging colour map core: input register, palette interpolation, result register.
// Each beat passes the input and result registers once; the result register drives the response.
// Throughput: one beat per cycle while the response is not stalled.
// Request ready falls only when both registers hold beats and the response is stalled.
// Reset: synchronous, active high; clears both valid flags, no buffered beats survive.
module diverging_colormap_lookup_core #(
   parameter int FRAC_BITS = dcm_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dcm_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [25:0] sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dcm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [7:0] red, [15:8] green, [23:16] blue
   output logic                             rsp_tuser   // [0] out_of_range
);

   localparam int SW     = dcm_pkg::SAMPLE_W;
   localparam int FRAC_W = FRAC_BITS - 2;
   localparam int CW     = (FRAC_BITS + 3 > SW + 1) ? FRAC_BITS + 3 : SW + 1;
   localparam logic signed [CW-1:0] ONE_VAL = CW'(1) <<< FRAC_BITS;
   localparam dcm_pkg::rgb_type LAST_C =
      dcm_pkg::palette(dcm_pkg::SEG_IDX_W'(dcm_pkg::PAL_LAST));

   logic                  s1_valid_ff, s1_valid_in;
   logic [SW-1:0]         sample_ff, sample_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dcm_pkg::rgb_type      colour_ff, colour_in;
   logic                  oor_ff, oor_in;

   logic                  s2_ready;
   logic                  s1_advance;
   logic signed [CW-1:0]  samp_ext;
   logic [CW-1:0]         n_idx;
   logic [dcm_pkg::SEG_IDX_W-1:0] seg;
   logic [FRAC_W-1:0]     frac;
   dcm_pkg::rgb_type      base_c, next_c, interp_c;

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;

   always_comb begin
      samp_ext = {{(CW-SW){sample_ff[SW-1]}}, sample_ff};
      n_idx    = samp_ext + ONE_VAL;
      seg      = n_idx[FRAC_BITS+1 -: dcm_pkg::SEG_IDX_W];
      frac     = n_idx[FRAC_W-1:0];
      base_c   = dcm_pkg::palette(seg);
      next_c   = dcm_pkg::palette(seg + dcm_pkg::SEG_IDX_W'(1));
   end

   dcm_chan #(.FRAC_W(FRAC_W)) u_red (
      .base(base_c.red), .next(next_c.red), .frac(frac), .value(interp_c.red)
   );
   dcm_chan #(.FRAC_W(FRAC_W)) u_green (
      .base(base_c.green), .next(next_c.green), .frac(frac), .value(interp_c.green)
   );
   dcm_chan #(.FRAC_W(FRAC_W)) u_blue (
      .base(base_c.blue), .next(next_c.blue), .frac(frac), .value(interp_c.blue)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      colour_in    = colour_ff;
      oor_in       = oor_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         sample_in   = req_tdata[SW-1:0];
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         oor_in       = (samp_ext < -ONE_VAL) || (samp_ext > ONE_VAL);
         if (oor_in) begin
            colour_in = dcm_pkg::BLACK;
         end else if (seg >= dcm_pkg::SEG_IDX_W'(dcm_pkg::PAL_LAST)) begin
            colour_in = dcm_pkg::palette(dcm_pkg::SEG_IDX_W'(dcm_pkg::PAL_LAST));
         end else begin
            colour_in = interp_c;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      colour_ff <= colour_in;
      oor_ff    <= oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {colour_ff.blue, colour_ff.green, colour_ff.red};
   assign rsp_tuser  = oor_ff;

   a_oor_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("out-of-range beat carries a colour");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("beats survive reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request accepted while pipeline full and stalled");

   a_plus_one: assert property (@(posedge clock) disable iff (reset)
      s1_advance && samp_ext == ONE_VAL |=> rsp_tdata == LAST_C && !rsp_tuser)
      else $error("plus one does not give the last palette entry");

endmodule

// ----- hdl/dcm_chan.sv -----
// One colour channel: linear step between two palette entries, rounded down.
module dcm_chan #(
   parameter int FRAC_W = dcm_pkg::FRAC_BITS_DEF - 2
) (
   input  logic [dcm_pkg::CHAN_W-1:0] base,
   input  logic [dcm_pkg::CHAN_W-1:0] next,
   input  logic [FRAC_W-1:0]          frac,
   output logic [dcm_pkg::CHAN_W-1:0] value
);

   localparam int PW = FRAC_W + dcm_pkg::CHAN_W;

   logic                      rising;
   logic [dcm_pkg::CHAN_W-1:0] diff;
   logic [PW-1:0]             prod;
   logic [dcm_pkg::CHAN_W-1:0] step;
   logic                      rem_nz;

   always_comb begin
      rising = (next >= base);
      diff   = rising ? (next - base) : (base - next);
      prod   = PW'(diff) * PW'(frac);
      step   = prod[PW-1:FRAC_W];
      rem_nz = |prod[FRAC_W-1:0];
      if (rising) begin
         value = base + step;
      end else begin
         value = base - step - dcm_pkg::CHAN_W'(rem_nz);
      end
   end

endmodule
